// ===== rtl/sjl_pkg.sv =====
// ----------------------------------------------------------------------------
// sjl_pkg
// Shared widths, register indexes and reset values for the seam jump limiter.
// ----------------------------------------------------------------------------
package sjl_pkg;

  localparam int VALUE_W = 32;
  localparam int RANK_W  = 8;
  localparam int COUNT_W = 16;
  localparam int CFG_W   = 16;
  localparam int IMG_W   = 8;
  localparam int TOL_W   = 24;
  localparam int CIDX_W  = 2;

  typedef enum logic [CIDX_W-1:0] {
    CFG_MAX_JUMP_WIDTH  = 2'd0,
    CFG_START_IMAGE     = 2'd1,
    CFG_WIDTH_INCREMENT = 2'd2
  } cfg_index_t;

  localparam logic [CFG_W-1:0]   MAX_JUMP_RESET  = 16'd50;
  localparam logic [IMG_W-1:0]   START_IMG_RESET = 8'd2;
  localparam logic [CFG_W-1:0]   WIDTH_INC_RESET = 16'd0;

  localparam logic [TOL_W-1:0]   TOL_MAX   = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [IMG_W-1:0]   IMG_MAX   = '1;

endpackage

// ===== rtl/sjl_in_if.sv =====
// ----------------------------------------------------------------------------
// sjl_in_if
// Input channel: seam start events and seam position samples.
// ----------------------------------------------------------------------------
interface sjl_in_if import sjl_pkg::*; ();

  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic                      first_in_image;
  logic signed [VALUE_W-1:0] sample_value;
  logic        [RANK_W-1:0]  sample_rank;

  modport source (
    output valid, kind, first_in_image, sample_value, sample_rank,
    input  ready
  );

  modport sink (
    input  valid, kind, first_in_image, sample_value, sample_rank,
    output ready
  );

endinterface

// ===== rtl/sjl_out_if.sv =====
// ----------------------------------------------------------------------------
// sjl_out_if
// Output channel: passed or held seam position with its rank and jump count.
// ----------------------------------------------------------------------------
interface sjl_out_if import sjl_pkg::*; ();

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] out_value;
  logic        [RANK_W-1:0]  out_rank;
  logic        [COUNT_W-1:0] jump_count;

  modport source (
    output valid, out_value, out_rank, jump_count,
    input  ready
  );

  modport sink (
    input  valid, out_value, out_rank, jump_count,
    output ready
  );

endinterface

// ===== rtl/seam_jump_limiter.sv =====
// A sample beat goes through the compare stage register and the output register.
// Throughput: one beat per cycle unless the output stalls; the held-value memory is
// read at accept, written back from the compare stage, forwarding back-to-back hits.
// A seam start beat gives no result and never waits on the output side.
// Reset: configuration, counters and valid flags to their defaults; the held-value
// memory is not cleared, only entries written since the last seam start are read.
// ----------------------------------------------------------------------------
// seam_jump_limiter
// Spike rejection per row element: from the start image on, a sample that jumps too far
// from the held value is replaced by that held value, with a growing tolerance.
// ----------------------------------------------------------------------------
module seam_jump_limiter import sjl_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  sjl_in_if.sink            samples,
  sjl_out_if.source         results
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int PW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_ELEMENTS);

  // configuration
  logic [CFG_W-1:0] max_jump_width;
  logic [IMG_W-1:0] start_image;
  logic [CFG_W-1:0] width_increment;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_jump_width  <= MAX_JUMP_RESET;
      start_image     <= START_IMG_RESET;
      width_increment <= WIDTH_INC_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MAX_JUMP_WIDTH:  max_jump_width  <= cfg_data;
        CFG_START_IMAGE:     start_image     <= cfg_data[IMG_W-1:0];
        CFG_WIDTH_INCREMENT: width_increment <= cfg_data;
        default: ;
      endcase
    end
  end

  // held pair per element
  logic [VALUE_W-1:0] held_values [MAX_ELEMENTS];
  logic [RANK_W-1:0]  held_ranks  [MAX_ELEMENTS];
  logic [VALUE_W-1:0] rd_value;
  logic [RANK_W-1:0]  rd_rank;
  logic               fwd_hit;
  logic [VALUE_W-1:0] fwd_value;
  logic [RANK_W-1:0]  fwd_rank;

  // position state, updated at accept
  logic [PW-1:0]    stored_length;
  logic [PW-1:0]    element_position;
  logic [IMG_W-1:0] image_count;

  // tolerance state, updated when the beat leaves the compare stage
  logic [TOL_W-1:0]   tolerance_now;
  logic [COUNT_W-1:0] rejection_total;

  // compare stage
  logic                      b_valid;
  logic                      b_sample;
  logic                      b_load_tol;
  logic                      b_active;
  logic                      b_have;
  logic                      b_store;
  logic [AW-1:0]             b_addr;
  logic signed [VALUE_W-1:0] b_value;
  logic [RANK_W-1:0]         b_rank;

  // output register
  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_value;
  logic [RANK_W-1:0]         out_rank;
  logic [COUNT_W-1:0]        jump_count;

  // accept stage
  logic             in_accept;
  logic             a_first;
  logic [PW-1:0]    a_pos;
  logic [PW-1:0]    a_pos_inc;
  logic [IMG_W-1:0] a_image;
  logic [AW-1:0]    a_rd_idx;
  logic             a_store;

  always_comb begin
    a_first   = samples.first_in_image;
    a_pos     = a_first ? '0 : element_position;
    a_pos_inc = a_pos + PW'(1);
    a_image   = (a_first && image_count != IMG_MAX) ? image_count + IMG_W'(1) : image_count;
    a_store   = a_pos < POS_LIMIT;
    // past the stored length: compare against the last stored entry
    if (a_pos >= stored_length) begin
      a_rd_idx = AW'(stored_length - PW'(1));
    end else begin
      a_rd_idx = a_pos[AW-1:0];
    end
  end

  // compare and select
  logic                 out_free;
  logic                 b_go;
  logic [TOL_W-1:0]     tol_base;
  logic [VALUE_W-1:0]   last_value;
  logic [RANK_W-1:0]    last_rank;
  logic [VALUE_W:0]     diff;
  logic [VALUE_W:0]     mag;
  logic                 reject;
  logic [TOL_W:0]       tol_sum;
  logic [TOL_W-1:0]     tol_next;
  logic [COUNT_W-1:0]   rej_next;
  logic [VALUE_W-1:0]   res_value;
  logic [RANK_W-1:0]    res_rank;
  logic                 wr_en;

  always_comb begin
    out_free = !out_valid || results.ready;
    b_go     = b_valid && (!b_sample || out_free);
    tol_base = b_load_tol ? TOL_W'(max_jump_width) : tolerance_now;
    if (b_have) begin
      last_value = fwd_hit ? fwd_value : rd_value;
      last_rank  = fwd_hit ? fwd_rank  : rd_rank;
    end else begin
      last_value = b_value;
      last_rank  = b_rank;
    end
    diff    = {last_value[VALUE_W-1], last_value} - {b_value[VALUE_W-1], b_value};
    mag     = diff[VALUE_W] ? -diff : diff;
    reject  = b_active && (mag > {1'b0, tol_base, 8'b0});
    tol_sum = {1'b0, tol_base} + (TOL_W+1)'(width_increment);

    if (!b_sample) begin
      tol_next = TOL_W'(max_jump_width);
    end else if (reject) begin
      tol_next = tol_sum[TOL_W] ? TOL_MAX : tol_sum[TOL_W-1:0];
    end else if (b_active) begin
      tol_next = TOL_W'(max_jump_width);
    end else begin
      tol_next = tol_base;
    end

    if (!b_sample) begin
      rej_next = '0;
    end else if (reject && rejection_total != COUNT_MAX) begin
      rej_next = rejection_total + COUNT_W'(1);
    end else begin
      rej_next = rejection_total;
    end

    res_value = reject ? last_value : b_value;
    res_rank  = reject ? last_rank  : b_rank;
    wr_en     = b_go && b_sample && b_store;
  end

  assign samples.ready = !b_valid || b_go;
  assign in_accept     = samples.valid && samples.ready;

  // memory: write-back from compare stage, registered read at accept
  always_ff @(posedge clk) begin
    if (wr_en) begin
      held_values[b_addr] <= res_value;
      held_ranks[b_addr]  <= res_rank;
    end
    if (in_accept) begin
      rd_value  <= held_values[a_rd_idx];
      rd_rank   <= held_ranks[a_rd_idx];
      // same-edge write to the entry being read: take the new pair
      fwd_hit   <= wr_en && (b_addr == a_rd_idx);
      fwd_value <= res_value;
      fwd_rank  <= res_rank;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_length    <= '0;
      element_position <= '0;
      image_count      <= '0;
    end else if (in_accept) begin
      if (!samples.kind) begin
        stored_length    <= '0;
        element_position <= '0;
        image_count      <= '0;
      end else begin
        image_count <= a_image;
        if (a_store) begin
          element_position <= a_pos_inc;
          if (stored_length < a_pos_inc) begin
            stored_length <= a_pos_inc;
          end
        end else begin
          element_position <= a_pos;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (samples.ready) begin
      b_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      b_sample   <= samples.kind;
      b_load_tol <= a_first && (image_count == '0);
      b_active   <= a_image >= start_image;
      b_have     <= stored_length != '0;
      b_store    <= a_store;
      b_addr     <= a_pos[AW-1:0];
      b_value    <= samples.sample_value;
      b_rank     <= samples.sample_rank;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance_now   <= '0;
      rejection_total <= '0;
    end else if (b_go) begin
      tolerance_now   <= tol_next;
      rejection_total <= rej_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_go && b_sample) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && b_sample) begin
      out_value  <= res_value;
      out_rank   <= res_rank;
      jump_count <= rej_next;
    end
  end

  assign results.valid      = out_valid;
  assign results.out_value  = out_value;
  assign results.out_rank   = out_rank;
  assign results.jump_count = jump_count;

endmodule

// ===== rtl/sjl_checker.sv =====
// ----------------------------------------------------------------------------
// sjl_checker
// Port-level checks for the seam jump limiter, bound to the top level.
// ----------------------------------------------------------------------------
module sjl_checker import sjl_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_kind,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [VALUE_W-1:0] out_value,
  input logic [RANK_W-1:0]         out_rank,
  input logic [COUNT_W-1:0]        jump_count
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_rank)
      && $stable(jump_count))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // a fresh result comes from an accepted sample beat
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_kind, 2))
    else $error("result without a matching sample beat");

  // input only backs up behind a waiting result
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

endmodule

bind seam_jump_limiter sjl_checker u_sjl_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (samples.valid),
  .in_ready   (samples.ready),
  .in_kind    (samples.kind),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_value  (results.out_value),
  .out_rank   (results.out_rank),
  .jump_count (results.jump_count)
);

// ===== sim/seam_jump_limiter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seam_jump_limiter_tb
// Self-checking bench for the seam jump limiter. A transaction-level predictor of
// the hold-last-value logic runs on every accepted input beat, and each output
// beat is compared field by field against the oldest prediction. The bench
// covers directed corner cases, the saturating counters, row overflow,
// output backpressure and randomized seams, with random bursts on the input
// side and random stalls on the output side.
// ----------------------------------------------------------------------------
module seam_jump_limiter_tb;
  import sjl_pkg::*;

  localparam int          ROW_MAX      = 1024;
  localparam int          DRAIN_CYCLES = 4;
  localparam int          QUIET_LIMIT  = 3000;
  localparam int          LONG_HOLD    = 300;
  localparam logic        KIND_SEAM_START = 1'b0;
  localparam logic        KIND_SAMPLE     = 1'b1;
  localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] VAL_MIN = 32'h8000_0000;

  typedef struct packed {
    logic        kind;
    logic        first_in_image;
    logic [31:0] value;
    logic [7:0]  rank;
  } seam_beat_t;

  typedef struct packed {
    logic [31:0] value;
    logic [7:0]  rank;
    logic [15:0] count;
  } limited_t;

  typedef enum {RDY_ALWAYS, RDY_MOSTLY, RDY_SPARSE, RDY_PERIODIC} ready_pattern_t;

  logic              clk;
  logic              rst;
  logic              cfg_write;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  sjl_in_if  samples_ch ();
  sjl_out_if results_ch ();

  seam_jump_limiter #(.MAX_ELEMENTS(ROW_MAX)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples_ch),
    .results   (results_ch)
  );

  // predictor state
  logic [31:0] held_val [ROW_MAX];
  logic [7:0]  held_rank [ROW_MAX];
  int unsigned row_len     = 0;
  int unsigned row_pos     = 0;
  int unsigned image_num   = 0;
  int unsigned tol_units   = 0;
  int unsigned reject_total = 0;
  int unsigned jump_limit          = MAX_JUMP_RESET;
  int unsigned first_corrected_img = START_IMG_RESET;
  int unsigned tol_step            = WIDTH_INC_RESET;

  limited_t limited_q[$];
  int       errors      = 0;
  int       quiet_cycles = 0;
  bit       pace_on     = 1'b1;
  bit       stall_req   = 1'b0;
  int       burst_left  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hold-last-value prediction for one accepted input beat
  task automatic limit_jump(input seam_beat_t b);
    limited_t    r;
    int unsigned pos;
    int unsigned idx;
    longint      last_v;
    longint      diff;
    longint      grown;
    logic [7:0]  last_r;
    if (b.kind == KIND_SEAM_START) begin
      image_num = 0;
      reject_total = 0;
      tol_units = jump_limit;
      row_len = 0;
      row_pos = 0;
      return;
    end
    r.value = b.value;
    r.rank = b.rank;
    if (b.first_in_image) begin
      row_pos = 0;
      if (image_num == 0) tol_units = jump_limit;
      if (image_num < 255) image_num++;
    end
    pos = row_pos;
    if (image_num >= first_corrected_img) begin
      last_v = longint'($signed(b.value));
      last_r = b.rank;
      if (row_len > 0) begin
        idx = (pos >= row_len) ? row_len - 1 : pos;
        last_v = longint'($signed(held_val[idx]));
        last_r = held_rank[idx];
      end
      diff = last_v - longint'($signed(b.value));
      if (diff < 0) diff = -diff;
      if (diff > longint'(tol_units) * 256) begin
        grown = longint'(tol_units) + longint'(tol_step);
        tol_units = (grown > longint'(TOL_MAX)) ? int'(TOL_MAX) : int'(grown);
        if (reject_total < 65535) reject_total++;
        r.value = last_v[31:0];
        r.rank = last_r;
      end else begin
        tol_units = jump_limit;
      end
    end
    if (pos < ROW_MAX) begin
      held_val[pos] = r.value;
      held_rank[pos] = r.rank;
      if (row_len < pos + 1) row_len = pos + 1;
      row_pos = pos + 1;
    end
    r.count = reject_total[15:0];
    limited_q = {limited_q, r};
  endtask

  task automatic send_beat(input seam_beat_t b);
    if (pace_on && burst_left == 0) begin
      samples_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    if (burst_left > 0) burst_left--;
    samples_ch.valid          <= 1'b1;
    samples_ch.kind           <= b.kind;
    samples_ch.first_in_image <= b.first_in_image;
    samples_ch.sample_value   <= b.value;
    samples_ch.sample_rank    <= b.rank;
    @(posedge clk);
    while (!samples_ch.ready) @(posedge clk);
    limit_jump(b);
  endtask

  task automatic send_sample(input logic first, input logic [31:0] value,
                             input logic [7:0] rank);
    send_beat('{KIND_SAMPLE, first, value, rank});
  endtask

  task automatic send_seam_start();
    send_beat('{KIND_SEAM_START, 1'($urandom), $urandom, 8'($urandom)});
  endtask

  task automatic wait_idle();
    samples_ch.valid <= 1'b0;
    while (limited_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] jump, input logic [7:0] start_img,
                              input logic [15:0] step);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= CFG_MAX_JUMP_WIDTH;
    cfg_data  <= jump;
    @(posedge clk);
    jump_limit = jump;
    cfg_index <= CFG_START_IMAGE;
    cfg_data  <= {8'd0, start_img};
    @(posedge clk);
    first_corrected_img = start_img;
    cfg_index <= CFG_WIDTH_INCREMENT;
    cfg_data  <= step;
    @(posedge clk);
    tol_step = step;
    cfg_write <= 1'b0;
  endtask

  // ------------------------------------------------------------------ tests

  // samples arrive before any image start or seam start: no correction yet
  task automatic test_reset_state();
    send_sample(1'b0, VAL_MAX, 8'hFF);
    send_sample(1'b0, VAL_MIN, 8'h00);
    send_sample(1'b0, 32'd0, 8'h5A);
  endtask

  // default registers: image 1 passes, image 2 on is corrected with 50.0
  task automatic test_seam_basics();
    send_seam_start();
    send_sample(1'b1, 32'd25600, 8'd1);
    send_sample(1'b0, -32'sd25600, 8'd2);
    send_sample(1'b0, 32'd0, 8'd3);
    send_sample(1'b1, 32'd25600 + 32'd12800, 8'd4);   // diff equals tolerance
    send_sample(1'b0, -32'sd25600 - 32'sd12801, 8'd5); // one LSB over
    send_sample(1'b0, VAL_MAX, 8'd6);
    send_sample(1'b0, 32'd100, 8'd7);                 // past stored length
    send_sample(1'b1, VAL_MIN, 8'd8);
  endtask

  task automatic test_register_extremes();
    program_regs(16'd0, 8'd1, 16'd1);
    send_seam_start();
    send_sample(1'b1, 32'd5, 8'd10);   // empty store passes
    send_sample(1'b0, 32'd5, 8'd11);
    send_sample(1'b0, 32'd6, 8'd12);
    send_sample(1'b0, 32'd7, 8'd13);
    program_regs(16'hFFFF, 8'd0, 16'hFFFF);
    send_seam_start();
    send_sample(1'b0, VAL_MAX, 8'hFF);
    send_sample(1'b0, VAL_MIN, 8'h00);
    send_sample(1'b0, VAL_MIN, 8'h80);
    send_sample(1'b1, 32'd0, 8'h01);
  endtask

  // one long row past the store; its head jumps full range every beat so the
  // tolerance climbs to its ceiling
  task automatic test_row_overflow();
    logic [31:0] v;
    program_regs(16'd0, 8'd0, 16'hFFFF);
    send_seam_start();
    for (int e = 0; e < ROW_MAX + 6; e++) begin
      if (e < 260) begin
        v = (e == 0) ? VAL_MIN : VAL_MAX;
      end else begin
        v = 32'(e * 64) + $urandom_range(0, 2 * 51200) - 32'd51200;
        if ($urandom_range(0, 9) == 0) v = $urandom;
      end
      send_sample(e == 0, v, 8'($urandom));
    end
    for (int e = 0; e < 8; e++) send_sample(e == 0, 32'(e * 64), 8'($urandom));
    for (int e = 0; e < 3; e++) send_sample(1'b0, $urandom, 8'($urandom));
  endtask

  task automatic test_image_saturation();
    program_regs(16'd1, 8'd255, 16'd3);
    send_seam_start();
    for (int i = 0; i < 260; i++)
      send_sample(1'b1, (i % 2) ? 32'h0010_0000 : 32'hFFF0_0000, 8'(i));
  endtask

  // output side holds off while the input keeps offering beats
  task automatic test_backpressure();
    program_regs(16'd20, 8'd2, 16'd5);
    pace_on = 1'b0;
    stall_req = 1'b1;
    send_seam_start();
    for (int i = 0; i < 48; i++)
      send_sample(i % 16 == 0, 32'(i * 300) + $urandom_range(0, 20000), 8'($urandom));
    wait_idle();
    pace_on = 1'b1;
  endtask

  task automatic test_random_seams(input int n_items);
    int          sent;
    int          n_img;
    int          row;
    int          pick;
    longint      span;
    logic        first;
    logic [31:0] v;
    logic [31:0] profile [16];
    logic [15:0] jump;
    logic [7:0]  start_img;
    logic [15:0] step;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 4))
          0:       jump = 16'd0;
          1:       jump = 16'hFFFF;
          default: jump = 16'($urandom_range(1, 300));
        endcase
        case ($urandom_range(0, 5))
          0:       start_img = 8'd0;
          1:       start_img = 8'd1;
          2:       start_img = 8'd2;
          3:       start_img = 8'd3;
          4:       start_img = 8'd255;
          default: start_img = 8'($urandom);
        endcase
        case ($urandom_range(0, 3))
          0:       step = 16'd0;
          1:       step = 16'hFFFF;
          default: step = 16'($urandom_range(1, 100));
        endcase
        program_regs(jump, start_img, step);
      end
      if ($urandom_range(0, 9) != 0) begin
        send_seam_start();
        sent++;
      end
      span = longint'(jump_limit) * 256;
      foreach (profile[e]) profile[e] = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
      n_img = $urandom_range(1, 6);
      row = $urandom_range(1, 16);
      for (int img = 0; img < n_img; img++) begin
        if ($urandom_range(0, 3) == 0) row = $urandom_range(1, 16);
        for (int e = 0; e < row; e++) begin
          pick = $urandom_range(0, 99);
          if (pick < 55)
            v = profile[e] + $urandom_range(0, 32'(2 * span + 2048)) - 32'(span + 1024);
          else if (pick < 70)
            v = ($urandom_range(0, 1) ? profile[e] + 32'(span) : profile[e] - 32'(span))
                + $urandom_range(0, 1);
          else if (pick < 85)
            v = profile[e] + {8'($urandom_range(1, 255)), 24'($urandom)};
          else
            v = $urandom;
          first = (e == 0);
          if ($urandom_range(0, 24) == 0) first = ~first;
          send_sample(first, v, 8'($urandom));
          sent++;
          if ($urandom_range(0, 15) == 0) begin
            send_beat('{1'($urandom), 1'($urandom), $urandom, 8'($urandom)});
            sent++;
          end
        end
      end
    end
  endtask

  // ------------------------------------------------------------ processes

  // output side: shifting stall patterns, plus one long hold on request
  initial begin
    ready_pattern_t pattern;
    int             pattern_left;
    int             hold_left;
    pattern = RDY_ALWAYS;
    pattern_left = 0;
    hold_left = 0;
    results_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        results_ch.ready <= 1'b0;
        if (hold_left == 0) stall_req = 1'b0;
      end else if (stall_req) begin
        hold_left = LONG_HOLD;
        results_ch.ready <= 1'b0;
      end else if (!pace_on) begin
        results_ch.ready <= 1'b1;
      end else begin
        if (pattern_left == 0) begin
          pattern = ready_pattern_t'($urandom_range(0, 3));
          pattern_left = $urandom_range(20, 200);
        end
        pattern_left--;
        case (pattern)
          RDY_ALWAYS:   results_ch.ready <= 1'b1;
          RDY_MOSTLY:   results_ch.ready <= ($urandom_range(0, 99) < 75);
          RDY_SPARSE:   results_ch.ready <= ($urandom_range(0, 99) < 25);
          RDY_PERIODIC: results_ch.ready <= (pattern_left % 4 != 0);
          default:      results_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    limited_t got;
    limited_t want;
    if (!rst && results_ch.valid && results_ch.ready) begin
      got = '{results_ch.out_value, results_ch.out_rank, results_ch.jump_count};
      if (limited_q.size() == 0) begin
        $display("%0t: unexpected beat: expected none, got value %0d rank %0d count %0d",
                 $time, $signed(got.value), got.rank, got.count);
        errors++;
      end else begin
        want = limited_q.pop_front();
        if (got.value !== want.value) begin
          $display("%0t: out_value expected %0d, got %0d",
                   $time, $signed(want.value), $signed(got.value));
          errors++;
        end
        if (got.rank !== want.rank) begin
          $display("%0t: out_rank expected %0d, got %0d", $time, want.rank, got.rank);
          errors++;
        end
        if (got.count !== want.count) begin
          $display("%0t: jump_count expected %0d, got %0d", $time, want.count, got.count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (samples_ch.valid && samples_ch.ready) ||
        (results_ch.valid && results_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst                       <= 1'b1;
    cfg_write                 <= 1'b0;
    cfg_index                 <= CFG_MAX_JUMP_WIDTH;
    cfg_data                  <= '0;
    samples_ch.valid          <= 1'b0;
    samples_ch.kind           <= KIND_SAMPLE;
    samples_ch.first_in_image <= 1'b0;
    samples_ch.sample_value   <= '0;
    samples_ch.sample_rank    <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_seam_basics();
    test_register_extremes();
    test_row_overflow();
    test_image_saturation();
    test_backpressure();
    test_random_seams(150);
    wait_idle();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
